>>> rtl/cdb_pkg.sv
// Shared command codes, printable character range and controller/datapath interface types.
`timescale 1ns / 1ps

package cdb_pkg;

  localparam logic [3:0] CMD_WRITE_CLAMP  = 4'd0;
  localparam logic [3:0] CMD_WRITE_SCROLL = 4'd1;
  localparam logic [3:0] CMD_CLEAR        = 4'd2;
  localparam logic [3:0] CMD_CLEAR_ROW    = 4'd3;
  localparam logic [3:0] CMD_UP           = 4'd4;
  localparam logic [3:0] CMD_DOWN         = 4'd5;
  localparam logic [3:0] CMD_LEFT         = 4'd6;
  localparam logic [3:0] CMD_RIGHT        = 4'd7;
  localparam logic [3:0] CMD_SET_POS      = 4'd8;
  localparam logic [3:0] CMD_READ         = 4'd9;

  localparam logic [7:0] CHAR_LOW  = 8'h20;
  localparam logic [7:0] CHAR_HIGH = 8'h7E;

  typedef struct packed {
    logic latch;
    logic exec;
    logic shift_step;
    logic shift_last;
    logic load;
  } cdb_cmd_t;

  typedef struct packed {
    logic scroll_shift;
    logic shift_end;
    logic out_free;
  } cdb_sts_t;

endpackage

>>> rtl/char_display_buffer_controller.sv
// Top level: character display buffer with cursor, stream in and stream out.
// Sequence: each command is accepted, executed and its result loaded into the output register;
//   a scroll-write at the last cell adds a shift walk over the display RAM, one cell per cycle.
// A new command is accepted only after the previous result has been loaded; a result held on
//   the output stalls the next accept.
// Reset: cursor and per-cell valid bits clear at once; no clearing pass.
`timescale 1ns / 1ps

module char_display_buffer_controller #(
  parameter int ROWS = 2,
  parameter int COLS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] command, [11:4] data_byte, [13:12] target_row, [18:14] target_column
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] ok, [1] cursor_row, [6:2] cursor_column, [14:7] read_data
  output logic [15:0] out_tdata
);

  cdb_pkg::cdb_cmd_t cmd;
  cdb_pkg::cdb_sts_t sts;

  cdb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdb_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

>>> rtl/cdb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/cdb_ctrl.sv
// Command sequencer: accepts a transfer, runs it, hands the result to the output register.
`timescale 1ns / 1ps

module cdb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cdb_pkg::cdb_sts_t sts,
  output cdb_pkg::cdb_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_LAST  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.scroll_shift ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_end) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        cmd.shift_last = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/cdb_datapath.sv
// Cursor, cell valid bits, display RAM ports and the result register.
`timescale 1ns / 1ps

module cdb_datapath #(
  parameter int ROWS = 2,
  parameter int COLS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [23:0]       in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,
  input  cdb_pkg::cdb_cmd_t cmd,
  output cdb_pkg::cdb_sts_t sts
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS > 1 ? CELLS : 2);
  localparam int RW    = $clog2(ROWS > 1 ? ROWS : 2);
  localparam int CW    = $clog2(COLS > 1 ? COLS : 2);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);
  localparam logic [7:0]    COLS8     = 8'(COLS);

  logic [3:0]       op_r;
  logic [7:0]       byte_r;
  logic [1:0]       trow_r;
  logic [4:0]       tcol_r;
  logic [RW-1:0]    cur_row_r, cur_row_nxt;
  logic [CW-1:0]    cur_col_r, cur_col_nxt;
  logic [CELLS-1:0] vld_r, vld_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic             ok_r, ok_nxt;
  logic             rvld_r;
  logic             out_tvalid_r;
  logic [15:0]      out_tdata_r;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [7:0]       wdata, rdata, rd_masked, rd_result;
  logic [7:0]       taddr_w, caddr_w;
  logic             at_last, printable, trow_ok, tcol_ok;

  assign taddr_w   = {6'd0, trow_r} * COLS8 + {3'd0, tcol_r};
  assign caddr_w   = 8'(cur_row_r) * COLS8 + 8'(cur_col_r);
  assign at_last   = (cur_row_r == LAST_ROW) && (cur_col_r == LAST_COL);
  assign printable = (byte_r >= cdb_pkg::CHAR_LOW) && (byte_r <= cdb_pkg::CHAR_HIGH);
  assign trow_ok   = {1'b0, trow_r} < 3'(ROWS);
  assign tcol_ok   = {1'b0, tcol_r} < 6'(COLS);
  assign rd_masked = rvld_r ? rdata : 8'd0;

  assign sts.scroll_shift = (op_r == cdb_pkg::CMD_WRITE_SCROLL) && at_last;
  assign sts.shift_end    = cnt_r == LAST_ADDR;
  assign sts.out_free     = !out_tvalid_r || out_tready;

  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    vld_nxt     = vld_r;
    cnt_nxt     = cnt_r;
    ok_nxt      = ok_r;
    we          = 1'b0;
    waddr       = caddr_w[AW-1:0];
    wdata       = byte_r;
    re          = 1'b0;
    raddr       = taddr_w[AW-1:0];

    if (cmd.exec) begin
      ok_nxt  = 1'b1;
      cnt_nxt = '0;
      unique case (op_r)
        cdb_pkg::CMD_WRITE_CLAMP, cdb_pkg::CMD_WRITE_SCROLL: begin
          if (op_r == cdb_pkg::CMD_WRITE_SCROLL || printable) begin
            if (!(op_r == cdb_pkg::CMD_WRITE_SCROLL && at_last)) begin
              we = 1'b1;
            end
            if (!at_last) begin
              if (cur_col_r != LAST_COL) begin
                cur_col_nxt = cur_col_r + 1'b1;
              end else begin
                if (cur_row_r != LAST_ROW) begin
                  cur_row_nxt = cur_row_r + 1'b1;
                end
                cur_col_nxt = '0;
              end
            end
          end
        end
        cdb_pkg::CMD_CLEAR: begin
          vld_nxt     = '0;
          cur_row_nxt = '0;
          cur_col_nxt = '0;
        end
        cdb_pkg::CMD_CLEAR_ROW: begin
          for (int r = 0; r < ROWS; r++) begin
            for (int j = 0; j < COLS; j++) begin
              if (cur_row_r == RW'(r)) begin
                vld_nxt[r*COLS+j] = 1'b0;
              end
            end
          end
          cur_col_nxt = '0;
        end
        cdb_pkg::CMD_UP: begin
          if (cur_row_r != '0) cur_row_nxt = cur_row_r - 1'b1;
          else ok_nxt = 1'b0;
        end
        cdb_pkg::CMD_DOWN: begin
          if (cur_row_r != LAST_ROW) cur_row_nxt = cur_row_r + 1'b1;
          else ok_nxt = 1'b0;
        end
        cdb_pkg::CMD_LEFT: begin
          if (cur_col_r != '0) cur_col_nxt = cur_col_r - 1'b1;
          else ok_nxt = 1'b0;
        end
        cdb_pkg::CMD_RIGHT: begin
          if (cur_col_r != LAST_COL) cur_col_nxt = cur_col_r + 1'b1;
          else ok_nxt = 1'b0;
        end
        cdb_pkg::CMD_SET_POS: begin
          if (!trow_ok) begin
            ok_nxt = 1'b0;
          end else begin
            cur_row_nxt = trow_r[RW-1:0];
            if (tcol_ok) cur_col_nxt = tcol_r[CW-1:0];
            else ok_nxt = 1'b0;
          end
        end
        cdb_pkg::CMD_READ: begin
          if (trow_ok && tcol_ok) re = 1'b1;
          else ok_nxt = 1'b0;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end

    // shift walk: read cell c+1 while writing cell c-1 with the previous read
    if (cmd.shift_step) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r != LAST_ADDR) begin
        re    = 1'b1;
        raddr = cnt_r + 1'b1;
      end
      if (cnt_r != '0) begin
        we    = 1'b1;
        waddr = cnt_r - 1'b1;
        wdata = rd_masked;
      end
    end

    if (cmd.shift_last) begin
      we    = 1'b1;
      waddr = LAST_ADDR;
      wdata = byte_r;
    end

    if (we) begin
      vld_nxt[waddr] = 1'b1;
    end
  end

  cdb_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_result = (op_r == cdb_pkg::CMD_READ && ok_r) ? rd_masked : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      vld_r     <= vld_nxt;
      if (cmd.load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_tdata[3:0];
      byte_r <= in_tdata[11:4];
      trow_r <= in_tdata[13:12];
      tcol_r <= in_tdata[18:14];
    end
    cnt_r <= cnt_nxt;
    ok_r  <= ok_nxt;
    if (re) begin
      rvld_r <= vld_r[raddr];
    end
    if (cmd.load) begin
      out_tdata_r <= {1'b0, rd_result, 5'(cur_col_r), cur_row_r[0], ok_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
